// ----- rtl/core/rmj_pkg.sv -----
// shared constants and types for the radar measurement jacobian pipeline
package rmj_pkg;

  // default field width and fraction bits of the Q format
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // multiplier bits consumed per multiplier pipeline row
  localparam int MUL_CHUNK = 8;

  // pipeline control handed to every stage group
  typedef struct packed {
    logic adv;    // whole pipeline moves one stage
    logic valid;  // item present at the group input
  } pipe_ctl_t;

endpackage

// ----- rtl/core/radar_measurement_jacobian_top.sv -----
// top level of the radar measurement jacobian pipeline
// One predicted state (px, py, vx, vy) goes in per transfer and one set of six
// Jacobian entries comes out, all signed fixed point with FRAC_BITS fraction
// bits, truncated toward zero and clamped to the signed range. A new state is
// taken every cycle while the skid register is empty. A state passes through
// one input register, three multiplier pipelines that retire eight multiplier
// bits per row with a sum register between the first and the second, root
// pipelines that settle one result bit per stage, a clamp register and the
// output register. Each entry is the largest k with k*k*den <= num for an
// exact integer pair, so every result is the exact floor of the root. A skid
// register behind the output lets one more state in while a result waits.
// When px and py are both zero all entries are zero and zero_range is set.
module radar_measurement_jacobian_top #(
  parameter int DATA_WIDTH = rmj_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = rmj_pkg::FRAC_BITS_DEF,
  localparam int InW       = ((4 * DATA_WIDTH + 7) / 8) * 8,
  localparam int OutW      = ((6 * DATA_WIDTH + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [InW-1:0]  s_axis_tdata,   // pos_x, pos_y, vel_x, vel_y
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [OutW-1:0] m_axis_tdata,   // drange_dx, drange_dy, dbearing_dx,
                                          // dbearing_dy, drate_dx, drate_dy
  output logic [1:0]      m_axis_tuser    // zero_range, saturated
);

  localparam int DW = DATA_WIDTH;
  localparam int FB = FRAC_BITS;
  localparam logic [DW-1:0] Half = {1'b1, {(DW - 1){1'b0}}};

  logic en;

  // clamp a magnitude to the signed range and apply the sign
  function automatic logic [DW:0] clamp(input logic [DW-1:0] m, input logic neg);
    logic [DW-1:0] lim;
    logic [DW-1:0] mv;
    logic          sat;
    lim = neg ? Half : Half - DW'(1);
    sat = m > lim;
    mv  = sat ? lim : m;
    return {sat, neg ? (~mv + DW'(1)) : mv};
  endfunction

  // input register: sign and magnitude of each field
  logic [DW-1:0] f1_mag_q [4];
  logic [3:0]    f1_neg_q;
  logic          f1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
    end else if (en) begin
      f1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        f1_neg_q[i] <= s_axis_tdata[i*DW + DW - 1];
        f1_mag_q[i] <= s_axis_tdata[i*DW + DW - 1] ? (~s_axis_tdata[i*DW +: DW] + DW'(1))
                                                   : s_axis_tdata[i*DW +: DW];
      end
    end
  end

  // first products: px^2, py^2, vx*py, vy*px
  rmj_pkg::pipe_ctl_t          ctl_a;
  logic                        a_valid;
  logic [3:0][2*DW-1:0]        a_prod;
  logic [2*DW+4:0]             a_side;
  logic                        f1_zero;

  assign f1_zero     = (f1_mag_q[0] == '0) && (f1_mag_q[1] == '0);
  assign ctl_a.adv   = en;
  assign ctl_a.valid = f1_valid_q;

  rmj_mul #(
    .LANES(4), .WA(DW), .WB(DW), .WS(2 * DW + 5)
  ) u_mul_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_a),
    .a_i     ({f1_mag_q[3], f1_mag_q[2], f1_mag_q[1], f1_mag_q[0]}),
    .b_i     ({f1_mag_q[0], f1_mag_q[1], f1_mag_q[1], f1_mag_q[0]}),
    .side_i  ({f1_zero, f1_neg_q, f1_mag_q[1], f1_mag_q[0]}),
    .valid_o (a_valid),
    .p_o     (a_prod),
    .side_o  (a_side)
  );

  // squared range, cross term w = vx*py - vy*px and result signs
  logic [DW-1:0]   a_px, a_py;
  logic [3:0]      a_neg;
  logic            a_zero;
  logic            uy_neg, vp_neg;
  logic [2*DW-1:0] w_d;
  logic            w_neg;
  logic [5:0]      sg_d;

  assign a_px   = a_side[DW-1:0];
  assign a_py   = a_side[2*DW-1:DW];
  assign a_neg  = a_side[2*DW+3:2*DW];
  assign a_zero = a_side[2*DW+4];
  assign uy_neg = a_neg[2] ^ a_neg[1];
  assign vp_neg = !(a_neg[3] ^ a_neg[0]);

  always_comb begin
    if (uy_neg == vp_neg) begin
      w_d   = a_prod[2] + a_prod[3];
      w_neg = uy_neg;
    end else if (a_prod[2] >= a_prod[3]) begin
      w_d   = a_prod[2] - a_prod[3];
      w_neg = uy_neg;
    end else begin
      w_d   = a_prod[3] - a_prod[2];
      w_neg = vp_neg;
    end
    sg_d[0] = a_neg[0];
    sg_d[1] = a_neg[1];
    sg_d[2] = !a_neg[1];
    sg_d[3] = a_neg[0];
    sg_d[4] = a_neg[1] ^ w_neg;
    sg_d[5] = a_neg[0] ^ !w_neg;
  end

  logic [2*DW-1:0] f2_q_q, f2_a2_q, f2_b2_q, f2_w_q;
  logic [DW-1:0]   f2_px_q, f2_py_q;
  logic [5:0]      f2_sg_q;
  logic            f2_zero_q;
  logic            f2_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f2_valid_q <= 1'b0;
    end else if (en) begin
      f2_valid_q <= a_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f2_q_q    <= a_prod[0] + a_prod[1];
      f2_a2_q   <= a_prod[0];
      f2_b2_q   <= a_prod[1];
      f2_w_q    <= w_d;
      f2_px_q   <= a_px;
      f2_py_q   <= a_py;
      f2_sg_q   <= sg_d;
      f2_zero_q <= a_zero;
    end
  end

  // second products: q^2, w*px, w*py
  rmj_pkg::pipe_ctl_t   ctl_b;
  logic                 b_valid;
  logic [2:0][4*DW-1:0] b_prod;
  logic [6*DW+6:0]      b_side;

  assign ctl_b.adv   = en;
  assign ctl_b.valid = f2_valid_q;

  rmj_mul #(
    .LANES(3), .WA(2 * DW), .WB(2 * DW), .WS(6 * DW + 7)
  ) u_mul_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_b),
    .a_i     ({f2_w_q, f2_w_q, f2_q_q}),
    .b_i     ({(2 * DW)'(f2_py_q), (2 * DW)'(f2_px_q), f2_q_q}),
    .side_i  ({f2_zero_q, f2_sg_q, f2_b2_q, f2_a2_q, f2_q_q}),
    .valid_o (b_valid),
    .p_o     (b_prod),
    .side_o  (b_side)
  );

  // third products: q^3, (w*px)^2, (w*py)^2
  rmj_pkg::pipe_ctl_t   ctl_c;
  logic                 c_valid;
  logic [2:0][7*DW-1:0] c_prod;
  logic [10*DW+6:0]     c_side;

  assign ctl_c.adv   = en;
  assign ctl_c.valid = b_valid;

  rmj_mul #(
    .LANES(3), .WA(4 * DW), .WB(3 * DW), .WS(10 * DW + 7)
  ) u_mul_c (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_c),
    .a_i     ({b_prod[2], b_prod[1], b_prod[0]}),
    .b_i     ({b_prod[2][3*DW-1:0], b_prod[1][3*DW-1:0], (3 * DW)'(b_side[2*DW-1:0])}),
    .side_i  ({b_side[6*DW+6:6*DW], b_prod[0], b_side[6*DW-1:0]}),
    .valid_o (c_valid),
    .p_o     (c_prod),
    .side_o  (c_side)
  );

  // unpack the carried values
  logic [2*DW-1:0] c_q, c_a2, c_b2;
  logic [4*DW-1:0] c_q2;
  logic [5:0]      c_sg;
  logic            c_zero;

  assign c_q    = c_side[2*DW-1:0];
  assign c_a2   = c_side[4*DW-1:2*DW];
  assign c_b2   = c_side[6*DW-1:4*DW];
  assign c_q2   = c_side[10*DW-1:6*DW];
  assign c_sg   = c_side[10*DW+5:10*DW];
  assign c_zero = c_side[10*DW+6];

  rmj_pkg::pipe_ctl_t ctl_r;
  assign ctl_r.adv   = en;
  assign ctl_r.valid = c_valid;

  // px/r and py/r from (v^2 2^2F) / q
  localparam int WN0 = 2 * DW + 2 * FB;
  logic            r0_valid;
  logic [1:0][DW-1:0] r0_m;
  logic [2:0]      r0_side;

  rmj_root #(
    .LANES(2), .WN(WN0), .WD(2 * DW), .K(DW), .WS(3)
  ) u_root_range (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_r),
    .n_i     ({WN0'(c_b2) << (2 * FB), WN0'(c_a2) << (2 * FB)}),
    .d_i     (c_q),
    .side_i  ({c_zero, c_sg[1], c_sg[0]}),
    .valid_o (r0_valid),
    .m_o     (r0_m),
    .side_o  (r0_side)
  );

  // py/q and px/q from (v^2 2^4F) / q^2
  localparam int WN1 = 2 * DW + 4 * FB;
  logic            r1_valid;
  logic [1:0][DW-1:0] r1_m;
  logic [1:0]      r1_side;

  rmj_root #(
    .LANES(2), .WN(WN1), .WD(4 * DW), .K(DW), .WS(2)
  ) u_root_bearing (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_r),
    .n_i     ({WN1'(c_a2) << (4 * FB), WN1'(c_b2) << (4 * FB)}),
    .d_i     (c_q2),
    .side_i  ({c_sg[3], c_sg[2]}),
    .valid_o (r1_valid),
    .m_o     (r1_m),
    .side_o  (r1_side)
  );

  // range-rate terms from ((v w)^2 2^2F) / q^3
  localparam int WN2 = 6 * DW + 2 * FB;
  logic            r2_valid;
  logic [1:0][DW-1:0] r2_m;
  logic [1:0]      r2_side;

  rmj_root #(
    .LANES(2), .WN(WN2), .WD(6 * DW), .K(DW), .WS(2)
  ) u_root_rate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_r),
    .n_i     ({WN2'(c_prod[1][6*DW-1:0]) << (2 * FB),
               WN2'(c_prod[2][6*DW-1:0]) << (2 * FB)}),
    .d_i     (c_prod[0][6*DW-1:0]),
    .side_i  ({c_sg[5], c_sg[4]}),
    .valid_o (r2_valid),
    .m_o     (r2_m),
    .side_o  (r2_side)
  );

  // clamp and sign each entry, zero range forces all entries to zero
  logic [DW-1:0]   ent_m   [6];
  logic [5:0]      ent_neg;
  logic [6*DW-1:0] clamp_data;
  logic            clamp_sat;

  assign ent_m[0] = r0_m[0];
  assign ent_m[1] = r0_m[1];
  assign ent_m[2] = r1_m[0];
  assign ent_m[3] = r1_m[1];
  assign ent_m[4] = r2_m[0];
  assign ent_m[5] = r2_m[1];
  assign ent_neg  = {r2_side, r1_side, r0_side[1:0]};

  always_comb begin
    logic [DW:0] c;
    clamp_sat  = 1'b0;
    clamp_data = '0;
    for (int e = 0; e < 6; e++) begin
      c                      = clamp(ent_m[e], ent_neg[e]);
      clamp_sat              = clamp_sat | c[DW];
      clamp_data[e*DW +: DW] = c[DW-1:0];
    end
    if (r0_side[2]) begin
      clamp_sat  = 1'b0;
      clamp_data = '0;
    end
  end

  logic [6*DW-1:0] p_data_q;
  logic [1:0]      p_user_q;
  logic            p_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (en) begin
      p_valid_q <= r0_valid & r1_valid & r2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_data_q <= clamp_data;
      p_user_q <= {clamp_sat, r0_side[2]};
    end
  end

  // output register with a skid register behind it
  logic [6*DW-1:0] out_data_q, skid_data_q;
  logic [1:0]      out_user_q, skid_user_q;
  logic            out_valid_q, out_valid_d;
  logic            skid_valid_q, skid_valid_d;
  logic            out_from_skid, out_from_pipe, skid_load;

  assign en = !skid_valid_q;

  always_comb begin
    out_valid_d   = out_valid_q;
    skid_valid_d  = skid_valid_q;
    out_from_skid = 1'b0;
    out_from_pipe = 1'b0;
    skid_load     = 1'b0;
    if (skid_valid_q) begin
      if (!out_valid_q || m_axis_tready) begin
        out_valid_d   = 1'b1;
        skid_valid_d  = 1'b0;
        out_from_skid = 1'b1;
      end
    end else if (p_valid_q) begin
      if (!out_valid_q || m_axis_tready) begin
        out_valid_d   = 1'b1;
        out_from_pipe = 1'b1;
      end else begin
        skid_valid_d  = 1'b1;
        skid_load     = 1'b1;
      end
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_from_skid) begin
      out_data_q <= skid_data_q;
      out_user_q <= skid_user_q;
    end else if (out_from_pipe) begin
      out_data_q <= p_data_q;
      out_user_q <= p_user_q;
    end
    if (skid_load) begin
      skid_data_q <= p_data_q;
      skid_user_q <= p_user_q;
    end
  end

  assign s_axis_tready = en;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutW'(out_data_q);
  assign m_axis_tuser  = out_user_q;

endmodule

// ----- rtl/core/rmj_mul.sv -----
// pipelined unsigned multiplier lanes, one multiplier chunk per stage
module rmj_mul #(
  parameter int LANES = 1,
  parameter int WA    = 8,
  parameter int WB    = 8,
  parameter int WS    = 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rmj_pkg::pipe_ctl_t              ctl_i,
  input  logic [LANES-1:0][WA-1:0]        a_i,
  input  logic [LANES-1:0][WB-1:0]        b_i,
  input  logic [WS-1:0]                   side_i,
  output logic                            valid_o,
  output logic [LANES-1:0][WA+WB-1:0]     p_o,
  output logic [WS-1:0]                   side_o
);

  localparam int Ch   = rmj_pkg::MUL_CHUNK;
  localparam int NStg = (WB + Ch - 1) / Ch;
  localparam int WBp  = NStg * Ch;
  localparam int WAcc = WA + WBp;
  localparam int WPp  = WA + Ch;

  logic [NStg-1:0]                 valid_q;
  logic [LANES-1:0][WA-1:0]        a_q    [NStg];
  logic [LANES-1:0][WBp-1:0]       b_q    [NStg];
  logic [LANES-1:0][WAcc-1:0]      acc_q  [NStg];
  logic [WS-1:0]                   side_q [NStg];

  for (genvar s = 0; s < NStg; s++) begin : g_stg
    logic                      v_in;
    logic [LANES-1:0][WA-1:0]  a_in;
    logic [LANES-1:0][WBp-1:0] b_in;
    logic [LANES-1:0][WAcc-1:0] acc_in;
    logic [LANES-1:0][WAcc-1:0] acc_nx;
    logic [WS-1:0]             side_in;

    if (s == 0) begin : g_first
      assign v_in    = ctl_i.valid;
      assign a_in    = a_i;
      assign acc_in  = '0;
      assign side_in = side_i;
      for (genvar l = 0; l < LANES; l++) begin : g_pad
        assign b_in[l] = WBp'(b_i[l]);
      end
    end else begin : g_next
      assign v_in    = valid_q[s-1];
      assign a_in    = a_q[s-1];
      assign b_in    = b_q[s-1];
      assign acc_in  = acc_q[s-1];
      assign side_in = side_q[s-1];
    end

    // partial product of one chunk, added at its weight
    always_comb begin
      logic [WPp-1:0] pp;
      for (int l = 0; l < LANES; l++) begin
        pp        = WPp'(a_in[l]) * WPp'(b_in[l][s*Ch +: Ch]);
        acc_nx[l] = acc_in[l] + (WAcc'(pp) << (s * Ch));
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (ctl_i.adv) begin
        valid_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.adv) begin
        a_q[s]    <= a_in;
        b_q[s]    <= b_in;
        acc_q[s]  <= acc_nx;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[NStg-1];
  assign side_o  = side_q[NStg-1];
  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign p_o[l] = acc_q[NStg-1][l][WA+WB-1:0];
  end

endmodule

// ----- rtl/core/rmj_root.sv -----
// pipelined root of a ratio: largest k with k*k*d <= n, one result bit per stage
module rmj_root #(
  parameter int LANES = 2,
  parameter int WN    = 16,
  parameter int WD    = 8,
  parameter int K     = 8,
  parameter int WS    = 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  rmj_pkg::pipe_ctl_t       ctl_i,
  input  logic [LANES-1:0][WN-1:0] n_i,
  input  logic [WD-1:0]            d_i,
  input  logic [WS-1:0]            side_i,
  output logic                     valid_o,
  output logic [LANES-1:0][K-1:0]  m_o,
  output logic [WS-1:0]            side_o
);

  localparam int WProd = WD + K;
  localparam int WT    = ((WN > WD + 2 * K) ? WN : WD + 2 * K) + 2;

  logic [K-1:0]                   valid_q;
  logic [LANES-1:0][WN-1:0]       r_q    [K];
  logic [LANES-1:0][WProd-1:0]    s_q    [K];
  logic [LANES-1:0][K-1:0]        k_q    [K];
  logic [WD-1:0]                  d_q    [K];
  logic [WS-1:0]                  side_q [K];

  for (genvar i = 0; i < K; i++) begin : g_stg
    localparam int J = K - 1 - i;
    logic                        v_in;
    logic [LANES-1:0][WN-1:0]    r_in,  r_nx;
    logic [LANES-1:0][WProd-1:0] s_in,  s_nx;
    logic [LANES-1:0][K-1:0]     k_in,  k_nx;
    logic [WD-1:0]               d_in;
    logic [WS-1:0]               side_in;

    if (i == 0) begin : g_first
      assign v_in    = ctl_i.valid;
      assign r_in    = n_i;
      assign s_in    = '0;
      assign k_in    = '0;
      assign d_in    = d_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = valid_q[i-1];
      assign r_in    = r_q[i-1];
      assign s_in    = s_q[i-1];
      assign k_in    = k_q[i-1];
      assign d_in    = d_q[i-1];
      assign side_in = side_q[i-1];
    end

    // trial bit: (k + 2^j)^2 d - k^2 d = 2^(j+1) k d + 2^(2j) d
    always_comb begin
      logic [WT-1:0] t;
      for (int l = 0; l < LANES; l++) begin
        t = (WT'(s_in[l]) << (J + 1)) + (WT'(d_in) << (2 * J));
        if (WT'(r_in[l]) >= t) begin
          r_nx[l] = WN'(WT'(r_in[l]) - t);
          s_nx[l] = s_in[l] + (WProd'(d_in) << J);
          k_nx[l] = k_in[l] | (K'(1) << J);
        end else begin
          r_nx[l] = r_in[l];
          s_nx[l] = s_in[l];
          k_nx[l] = k_in[l];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else if (ctl_i.adv) begin
        valid_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.adv) begin
        r_q[i]    <= r_nx;
        s_q[i]    <= s_nx;
        k_q[i]    <= k_nx;
        d_q[i]    <= d_in;
        side_q[i] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[K-1];
  assign m_o     = k_q[K-1];
  assign side_o  = side_q[K-1];

endmodule

// ----- rtl/core/rmj_checker.sv -----
// port level checks for the radar measurement jacobian top, bound to it
module rmj_checker #(
  parameter int DATA_WIDTH = rmj_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = rmj_pkg::FRAC_BITS_DEF,
  localparam int OutW      = ((6 * DATA_WIDTH + 7) / 8) * 8
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            s_axis_tready,
  input logic            m_axis_tvalid,
  input logic            m_axis_tready,
  input logic [OutW-1:0] m_axis_tdata,   // drange_dx, drange_dy, dbearing_dx,
                                         // dbearing_dy, drate_dx, drate_dy
  input logic [1:0]      m_axis_tuser    // zero_range, saturated
);

  localparam longint Unit = 64'sd1 <<< FRAC_BITS;

  logic signed [DATA_WIDTH-1:0] drange_dx;
  assign drange_dx = m_axis_tdata[DATA_WIDTH-1:0];

  // zero range gives an all-zero matrix and no clamp
  a_zero_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tdata == '0) && !m_axis_tuser[1])
    else $error("zero range result carries nonzero entries");

  // px over range never exceeds one in magnitude
  a_unit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (longint'(drange_dx) <= Unit) && (longint'(drange_dx) >= -Unit))
    else $error("drange_dx outside unit range");

  // the input side is open whenever no result is pending
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind radar_measurement_jacobian_top rmj_checker #(
  .DATA_WIDTH(DATA_WIDTH),
  .FRAC_BITS (FRAC_BITS)
) u_rmj_checker (.*);

// ----- tb/sv/tb_top.sv -----
// self-checking testbench for the radar measurement jacobian pipeline
`timescale 1ns / 100ps

module tb_top;

  localparam int DW       = rmj_pkg::DATA_WIDTH_DEF;
  localparam int FB       = rmj_pkg::FRAC_BITS_DEF;
  localparam int IN_W     = ((4 * DW + 7) / 8) * 8;
  localparam int OUT_W    = ((6 * DW + 7) / 8) * 8;
  localparam int LATENCY  = 2 + (DW + 7) / 8 + (2 * DW + 7) / 8 + (3 * DW + 7) / 8 + DW + 2;
  localparam int N_RANDOM = 1540;

  typedef logic [255:0] wide_t;

  typedef struct packed {
    logic [DW-1:0] vel_y;
    logic [DW-1:0] vel_x;
    logic [DW-1:0] pos_y;
    logic [DW-1:0] pos_x;
  } track_state_t;

  typedef struct {
    logic [DW-1:0] entry[6];
    logic          zero_range;
    logic          saturated;
  } jacobian_t;

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;
  logic [1:0]       m_axis_tuser;

  jacobian_t jacobian_q[$];
  int        fail_cnt;
  bit        tx_idle_en;
  bit        rx_idle_en;
  int        rx_hold_len;
  int        rx_stall_left;

  radar_measurement_jacobian_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // clock and reset
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // floor square root of a wide value
  function automatic wide_t floor_root(wide_t a);
    wide_t r;
    wide_t c;
    r = '0;
    for (int k = 127; k >= 0; k--) begin
      c = r | (wide_t'(1) << k);
      if (c * c <= a) r = c;
    end
    return r;
  endfunction

  // clamp a magnitude to the signed range and apply the sign
  function automatic logic [DW-1:0] signed_clamp(wide_t mag, bit neg, inout bit sat);
    wide_t lim;
    lim = neg ? (wide_t'(1) << (DW - 1)) : (wide_t'(1) << (DW - 1)) - 1;
    if (mag > lim) begin
      sat = 1'b1;
      mag = lim;
    end
    return neg ? DW'(-mag) : DW'(mag);
  endfunction

  // sign and magnitude of a field; the most negative value has magnitude 2^(W-1)
  function automatic wide_t field_mag(logic [DW-1:0] x, output bit neg);
    neg = x[DW-1];
    return neg ? (wide_t'(1) << DW) - wide_t'(x) : wide_t'(x);
  endfunction

  // expected jacobian entries for one predicted state
  function automatic jacobian_t predict_jacobian(track_state_t st);
    jacobian_t res;
    wide_t     ap, ay, au, av, q, q3, uy, vp, w, num;
    bit        np, ny, nu, nv, nw, a_neg, b_neg, sat;
    ap  = field_mag(st.pos_x, np);
    ay  = field_mag(st.pos_y, ny);
    au  = field_mag(st.vel_x, nu);
    av  = field_mag(st.vel_y, nv);
    sat = 1'b0;
    foreach (res.entry[i]) res.entry[i] = '0;
    res.zero_range = 1'b0;
    res.saturated  = 1'b0;
    if (ap == 0 && ay == 0) begin
      res.zero_range = 1'b1;
      return res;
    end
    q = ap * ap + ay * ay;
    // direction cosines
    res.entry[0] = signed_clamp(floor_root(((ap * ap) << (2 * FB)) / q), np, sat);
    res.entry[1] = signed_clamp(floor_root(((ay * ay) << (2 * FB)) / q), ny, sat);
    // bearing terms
    res.entry[2] = signed_clamp((ay << (2 * FB)) / q, !ny, sat);
    res.entry[3] = signed_clamp((ap << (2 * FB)) / q, np, sat);
    // cross term vx*py - vy*px in sign and magnitude
    uy    = au * ay;
    vp    = av * ap;
    a_neg = nu ^ ny;
    b_neg = !(nv ^ np);
    if (a_neg == b_neg) begin
      w  = uy + vp;
      nw = a_neg;
    end else if (uy >= vp) begin
      w  = uy - vp;
      nw = a_neg;
    end else begin
      w  = vp - uy;
      nw = b_neg;
    end
    // range rate terms
    q3  = q * q * q;
    num = (ay * w) << FB;
    res.entry[4] = signed_clamp(floor_root((num * num) / q3), ny ^ nw, sat);
    num = (ap * w) << FB;
    res.entry[5] = signed_clamp(floor_root((num * num) / q3), np ^ !nw, sat);
    res.saturated = sat;
    return res;
  endfunction

  // offer one state until the transfer completes, then maybe go idle
  task automatic send_state(track_state_t st);
    bit ok;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'(st);
    do begin
      @(negedge clk_i);
      ok = s_axis_tready;
      @(posedge clk_i);
    end while (!ok);
    jacobian_q.push_back(predict_jacobian(st));
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  task automatic send_fields(logic [DW-1:0] px, logic [DW-1:0] py,
                             logic [DW-1:0] vx, logic [DW-1:0] vy);
    track_state_t st;
    st.pos_x = px;
    st.pos_y = py;
    st.vel_x = vx;
    st.vel_y = vy;
    send_state(st);
  endtask

  // random field: full range, small magnitudes, extremes or zero
  function automatic logic [DW-1:0] rand_field();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return DW'($urandom);
      4, 5:       return DW'($signed($urandom_range(0, 2 << 20)) - (1 << 20));
      6:          return DW'($signed($urandom_range(0, 64)) - 32);
      7:          return {1'b1, {(DW - 1){1'b0}}};
      8:          return {1'b0, {(DW - 1){1'b1}}};
      default:    return '0;
    endcase
  endfunction

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (jacobian_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  // receiver side: long hold, random stall bursts or ready
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (rx_hold_len > 0) begin
      rx_hold_len   = rx_hold_len - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_stall_left > 0) begin
      rx_stall_left = rx_stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 6) == 0) begin
      rx_stall_left = $urandom_range(0, 14);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // compare each output transfer with the oldest expectation
  always @(negedge clk_i) begin
    jacobian_t exp_res;
    logic [DW-1:0] got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (jacobian_q.size() == 0) begin
        $display("%0t: unexpected result tdata %h tuser %b", $time, m_axis_tdata,
                 m_axis_tuser);
        fail_cnt++;
      end else begin
        exp_res = jacobian_q.pop_front();
        for (int i = 0; i < 6; i++) begin
          got = m_axis_tdata[i*DW +: DW];
          if (got !== exp_res.entry[i]) begin
            $display("%0t: entry %0d expected %h actual %h", $time, i,
                     exp_res.entry[i], got);
            fail_cnt++;
          end
        end
        if (m_axis_tuser[0] !== exp_res.zero_range) begin
          $display("%0t: zero_range expected %b actual %b", $time, exp_res.zero_range,
                   m_axis_tuser[0]);
          fail_cnt++;
        end
        if (m_axis_tuser[1] !== exp_res.saturated) begin
          $display("%0t: saturated expected %b actual %b", $time, exp_res.saturated,
                   m_axis_tuser[1]);
          fail_cnt++;
        end
      end
    end
  end

  // extremes, zero range, axis cases and saturation
  task automatic test_directed();
    logic [DW-1:0] vmax, vmin;
    vmax = {1'b0, {(DW - 1){1'b1}}};
    vmin = {1'b1, {(DW - 1){1'b0}}};
    send_fields('0, '0, '0, '0);
    send_fields('0, '0, vmax, vmin);
    send_fields(DW'(1 << FB), '0, '0, '0);
    send_fields('0, DW'(-(1 << FB)), DW'(3 << FB), DW'(5 << FB));
    send_fields(vmax, vmax, vmax, vmax);
    send_fields(vmin, vmin, vmin, vmin);
    send_fields(vmin, '0, vmax, vmin);
    send_fields('0, vmin, vmin, vmax);
    send_fields(vmax, vmin, vmin, vmax);
    send_fields(DW'(1), '0, '0, '0);
    send_fields(DW'(1), DW'(1), vmax, vmin);
    send_fields(DW'(-1), DW'(1), vmin, vmin);
    send_fields(DW'(3 << FB), DW'(4 << FB), DW'(3 << FB), DW'(4 << FB));
    send_fields(DW'(3 << FB), DW'(-(4 << FB)), DW'(-(2 << FB)), DW'(7 << FB));
    send_fields(DW'(5), DW'(7), DW'(1 << 20), DW'(-(1 << 20)));
    send_fields(DW'(-(12 << FB)), DW'(1), '1, DW'(1));
    wait_drained();
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++)
      send_fields(rand_field(), rand_field(), rand_field(), rand_field());
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    rx_hold_len = 400;
    test_random(120);
    wait_drained();
  endtask

  initial begin
    fail_cnt      = 0;
    tx_idle_en    = 1'b1;
    rx_idle_en    = 1'b1;
    rx_hold_len   = 0;
    rx_stall_left = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    test_directed();
    test_random(N_RANDOM / 2);
    test_backpressure();
    test_random(N_RANDOM / 2 - 120);
    wait_drained();
    // last part with no idling on either side
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random(200);
    wait_drained();
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(12 * 400000);
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/rmj_pkg.sv
rtl/core/rmj_mul.sv
rtl/core/rmj_root.sv
rtl/core/radar_measurement_jacobian_top.sv
rtl/core/rmj_checker.sv
tb/sv/tb_top.sv
